@@ hw/rtl/lk3_pkg.sv @@
package lk3_pkg;

    localparam logic [31:0] INIT_VAL = 32'hdeadbeef;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_LEN   = 2'd1;
    localparam logic [1:0] ST_SHORT = 2'd2;

    localparam logic [1:0] SLOT_A = 2'd0;
    localparam logic [1:0] SLOT_B = 2'd1;
    localparam logic [1:0] SLOT_C = 2'd2;

    localparam logic [2:0] MAX_BYTES = 3'd4;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } abc_t;

    typedef struct packed {
        logic        start;
        logic [31:0] init;
        logic [31:0] word;
        logic [1:0]  slot;
        logic        add;
        logic        mix;
        logic        last;
        logic        fin_en;
        logic [1:0]  status;
    } cmd_t;

    typedef struct packed {
        logic       valid;
        logic       skip;
        logic [1:0] status;
        abc_t       v;
    } hand_t;

    typedef struct packed {
        logic valid;
        abc_t v;
    } wb_t;

    function automatic logic [31:0] rot(logic [31:0] x, int s);
        return (x << s) | (x >> (32 - s));
    endfunction

    function automatic abc_t mix_l12(abc_t v);
        abc_t r;
        r = v;
        r.a = (r.a - r.c) ^ rot(r.c, 4);
        r.c = r.c + r.b;
        r.b = (r.b - r.a) ^ rot(r.a, 6);
        r.a = r.a + r.c;
        return r;
    endfunction

    function automatic abc_t mix_l34(abc_t v);
        abc_t r;
        r = v;
        r.c = (r.c - r.b) ^ rot(r.b, 8);
        r.b = r.b + r.a;
        r.a = (r.a - r.c) ^ rot(r.c, 16);
        r.c = r.c + r.b;
        return r;
    endfunction

    function automatic abc_t mix_l56(abc_t v);
        abc_t r;
        r = v;
        r.b = (r.b - r.a) ^ rot(r.a, 19);
        r.a = r.a + r.c;
        r.c = (r.c - r.b) ^ rot(r.b, 4);
        r.b = r.b + r.a;
        return r;
    endfunction

    function automatic abc_t fin_l12(abc_t v);
        abc_t r;
        r = v;
        r.c = (r.c ^ r.b) - rot(r.b, 14);
        r.a = (r.a ^ r.c) - rot(r.c, 11);
        return r;
    endfunction

    function automatic abc_t fin_l34(abc_t v);
        abc_t r;
        r = v;
        r.b = (r.b ^ r.a) - rot(r.a, 25);
        r.c = (r.c ^ r.b) - rot(r.b, 16);
        return r;
    endfunction

    function automatic abc_t fin_l56(abc_t v);
        abc_t r;
        r = v;
        r.a = (r.a ^ r.c) - rot(r.c, 4);
        r.b = (r.b ^ r.a) - rot(r.a, 14);
        return r;
    endfunction

    function automatic abc_t fin_l7(abc_t v);
        abc_t r;
        r = v;
        r.c = (r.c ^ r.b) - rot(r.b, 24);
        return r;
    endfunction

endpackage

@@ hw/rtl/lk3_front.sv @@
module lk3_front import lk3_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        take,
    input  logic        start_req,
    input  logic        last,
    input  logic [31:0] key_length,
    input  logic [31:0] data_word,
    input  logic [2:0]  byte_count,
    output cmd_t        cmd
);

    logic [1:0]  slot_reg, slot_next;
    logic        pend_reg, pend_next;
    logic [31:0] seen_reg, seen_next;
    logic [31:0] decl_reg, decl_next;
    logic        short_reg, short_next;

    logic [2:0]  cnt;
    logic [1:0]  slot_e, slot_u;
    logic        pend_e, short_e, has;
    logic [31:0] seen_e, decl_e;

    always_comb
    begin
        cnt     = (byte_count > MAX_BYTES) ? MAX_BYTES : byte_count;
        slot_e  = start_req ? SLOT_A : slot_reg;
        pend_e  = start_req ? 1'b0 : pend_reg;
        seen_e  = start_req ? 32'd0 : seen_reg;
        decl_e  = start_req ? key_length : decl_reg;
        short_e = start_req ? 1'b0 : short_reg;
        has     = (cnt != 3'd0);
        slot_u  = (has && pend_e) ? SLOT_A : slot_e;

        seen_next = seen_e + {29'd0, cnt};
        decl_next = decl_e;
        if (has)
        begin
            pend_next = (slot_u == SLOT_C);
            slot_next = (slot_u == SLOT_C) ? SLOT_A : slot_u + 2'd1;
        end
        else
        begin
            pend_next = pend_e;
            slot_next = slot_e;
        end
        short_next = (!last && (cnt < MAX_BYTES)) ? 1'b1 : short_e;

        cmd.start = start_req;
        cmd.init  = INIT_VAL + key_length;
        case (cnt)
            3'd0:    cmd.word = 32'd0;
            3'd1:    cmd.word = data_word & 32'h000000ff;
            3'd2:    cmd.word = data_word & 32'h0000ffff;
            3'd3:    cmd.word = data_word & 32'h00ffffff;
            default: cmd.word = data_word;
        endcase
        cmd.slot   = slot_u;
        cmd.add    = has;
        cmd.mix    = has && pend_e;
        cmd.last   = last;
        cmd.fin_en = (seen_next != 32'd0);
        if (short_e)
            cmd.status = ST_SHORT;
        else if (seen_next != decl_e)
            cmd.status = ST_LEN;
        else
            cmd.status = ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg  <= SLOT_A;
            pend_reg  <= 1'b0;
            seen_reg  <= 32'd0;
            decl_reg  <= 32'd0;
            short_reg <= 1'b0;
        end
        else if (take)
        begin
            slot_reg  <= slot_next;
            pend_reg  <= pend_next;
            seen_reg  <= seen_next;
            decl_reg  <= decl_next;
            short_reg <= short_next;
        end
    end

endmodule

@@ hw/rtl/lk3_cmd_fifo.sv @@
module lk3_cmd_fifo import lk3_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t din,
    input  logic rd_en,
    output cmd_t dout,
    output logic full,
    output logic valid
);

    cmd_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full  = (cnt_reg == 2'd2);
    assign valid = (cnt_reg != 2'd0);
    assign dout  = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr_en)
                wp_reg <= ~wp_reg;
            if (rd_en)
                rp_reg <= ~rp_reg;
            if (wr_en && !rd_en)
                cnt_reg <= cnt_reg + 2'd1;
            else if (!wr_en && rd_en)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wp_reg] <= din;
    end

endmodule

@@ hw/rtl/lk3_engine.sv @@
module lk3_engine import lk3_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  cmd_t  cmd,
    input  logic  cmd_valid,
    output logic  cmd_take,
    input  logic  adv,
    input  wb_t   wb,
    output hand_t hand,
    output logic  kill
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_MID  = 2'd1;
    localparam logic [1:0] PH_END  = 2'd2;

    abc_t       base_reg, base_next;
    abc_t       p_reg, p_next;
    logic [1:0] phase_reg, phase_next;
    logic       fpend_reg, fpend_next;
    logic       wait_reg, wait_next;
    logic [1:0] fstat_reg, fstat_next;
    logic       fskip_reg, fskip_next;

    abc_t addv, src, sum, pv, t;
    logic ok, take, hand_fire, wb_ok;

    always_comb
    begin
        addv = '0;
        if (cmd.add)
        begin
            case (cmd.slot)
                SLOT_A:  addv.a = cmd.word;
                SLOT_B:  addv.b = cmd.word;
                default: addv.c = cmd.word;
            endcase
        end
        src.a = cmd.start ? cmd.init : base_reg.a;
        src.b = cmd.start ? cmd.init : base_reg.b;
        src.c = cmd.start ? cmd.init : base_reg.c;
        sum.a = src.a + addv.a;
        sum.b = src.b + addv.b;
        sum.c = src.c + addv.c;

        if (phase_reg != PH_IDLE)
            ok = !cmd.start && !cmd.last && !fpend_reg;
        else if (fpend_reg)
            ok = 1'b0;
        else
            ok = (cmd.start || !wait_reg) && (!cmd.last || cmd.mix || adv);
        take = cmd_valid && ok;
        pv   = take ? addv : '0;
        t    = mix_l56(base_reg);

        base_next  = base_reg;
        p_next     = p_reg;
        phase_next = phase_reg;
        fpend_next = fpend_reg;
        fstat_next = fstat_reg;
        fskip_next = fskip_reg;
        hand       = '0;
        hand_fire  = 1'b0;

        case (phase_reg)
            PH_IDLE:
            begin
                if (fpend_reg)
                begin
                    if (adv)
                    begin
                        hand_fire   = 1'b1;
                        hand.v      = base_reg;
                        hand.skip   = fskip_reg;
                        hand.status = fstat_reg;
                        fpend_next  = 1'b0;
                    end
                end
                else if (take)
                begin
                    if (cmd.mix)
                    begin
                        base_next  = mix_l12(base_reg);
                        p_next     = addv;
                        phase_next = PH_MID;
                        if (cmd.last)
                        begin
                            fpend_next = 1'b1;
                            fstat_next = cmd.status;
                            fskip_next = !cmd.fin_en;
                        end
                    end
                    else
                    begin
                        base_next = sum;
                        if (cmd.last)
                        begin
                            hand_fire   = 1'b1;
                            hand.v      = sum;
                            hand.skip   = !cmd.fin_en;
                            hand.status = cmd.status;
                        end
                    end
                end
            end
            PH_MID:
            begin
                base_next  = mix_l34(base_reg);
                p_next.a   = p_reg.a + pv.a;
                p_next.b   = p_reg.b + pv.b;
                p_next.c   = p_reg.c + pv.c;
                phase_next = PH_END;
            end
            default:
            begin
                base_next.a = t.a + p_reg.a + pv.a;
                base_next.b = t.b + p_reg.b + pv.b;
                base_next.c = t.c + p_reg.c + pv.c;
                phase_next  = PH_IDLE;
            end
        endcase

        hand.valid = hand_fire;
        kill       = hand_fire || (take && cmd.start);
        wb_ok      = wb.valid && wait_reg && !kill && !take && (phase_reg == PH_IDLE);
        if (wb_ok)
            base_next = wb.v;

        if (hand_fire)
            wait_next = 1'b1;
        else if ((take && cmd.start) || wb_ok)
            wait_next = 1'b0;
        else
            wait_next = wait_reg;

        cmd_take = take;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= '0;
            phase_reg <= PH_IDLE;
            fpend_reg <= 1'b0;
            wait_reg  <= 1'b0;
        end
        else
        begin
            base_reg  <= base_next;
            phase_reg <= phase_next;
            fpend_reg <= fpend_next;
            wait_reg  <= wait_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg     <= p_next;
        fstat_reg <= fstat_next;
        fskip_reg <= fskip_next;
    end

endmodule

@@ hw/rtl/lk3_final.sv @@
module lk3_final import lk3_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  hand_t       hand,
    input  logic        kill,
    output logic        adv,
    output wb_t         wb,
    input  logic        pop,
    output logic        empty,
    output logic [31:0] hash_value,
    output logic [1:0]  status
);

    logic [3:0] vld_reg;
    logic [3:0] wbf_reg;
    logic [3:0] skip_reg;
    logic [1:0] st_reg [4];
    abc_t       v_reg  [4];

    logic [31:0] oh_reg [2];
    logic [1:0]  os_reg [2];
    logic        owp_reg, orp_reg;
    logic [1:0]  ocnt_reg;

    abc_t f7;
    logic opush, opop;

    always_comb
    begin
        adv   = (ocnt_reg != 2'd2);
        f7    = skip_reg[3] ? v_reg[3] : fin_l7(v_reg[3]);
        opush = adv && vld_reg[3];
        opop  = pop && (ocnt_reg != 2'd0);
        wb.valid = opush && wbf_reg[3];
        wb.v     = f7;
    end

    assign empty      = (ocnt_reg == 2'd0);
    assign hash_value = oh_reg[orp_reg];
    assign status     = os_reg[orp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= 4'd0;
            wbf_reg  <= 4'd0;
            owp_reg  <= 1'b0;
            orp_reg  <= 1'b0;
            ocnt_reg <= 2'd0;
        end
        else
        begin
            if (adv)
            begin
                vld_reg <= {vld_reg[2:0], hand.valid};
                wbf_reg <= {wbf_reg[2:0] & {3{!kill}}, hand.valid};
            end
            else if (kill)
            begin
                wbf_reg <= 4'd0;
            end
            if (opush)
                owp_reg <= ~owp_reg;
            if (opop)
                orp_reg <= ~orp_reg;
            if (opush && !opop)
                ocnt_reg <= ocnt_reg + 2'd1;
            else if (!opush && opop)
                ocnt_reg <= ocnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            v_reg[0]    <= hand.v;
            skip_reg[0] <= hand.skip;
            st_reg[0]   <= hand.status;
            v_reg[1]    <= skip_reg[0] ? v_reg[0] : fin_l12(v_reg[0]);
            v_reg[2]    <= skip_reg[1] ? v_reg[1] : fin_l34(v_reg[1]);
            v_reg[3]    <= skip_reg[2] ? v_reg[2] : fin_l56(v_reg[2]);
            skip_reg[3:1] <= skip_reg[2:0];
            st_reg[1]   <= st_reg[0];
            st_reg[2]   <= st_reg[1];
            st_reg[3]   <= st_reg[2];
        end
        if (opush)
        begin
            oh_reg[owp_reg] <= f7.c;
            os_reg[owp_reg] <= st_reg[3];
        end
    end

endmodule

@@ hw/rtl/lookup3_string_hash.sv @@
// Path: the last beat of a key goes from the command queue through the engine and the finalization
// registers into the result queue, after the engine's mix phases when that beat also starts a block mix.
// Throughput: one beat per cycle while the queue is not full; a start or last beat waits out the mix
// phases after a mix beat, and a beat continuing a finished key waits for the final-round writeback.
// Reset: rst_n clears accumulators, counters and queues; the block then hashes
// as if a key had begun with all accumulators zero.
module lookup3_string_hash import lk3_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        start_req,
    input  logic        last,
    input  logic [31:0] key_length,
    input  logic [31:0] data_word,
    input  logic [2:0]  byte_count,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] hash_value,
    output logic [1:0]  status
);

    cmd_t  cmd_in, cmd_out;
    logic  in_take, cmd_valid, cmd_take, adv, kill;
    hand_t hand;
    wb_t   wb;

    assign in_take = push && !full;

    lk3_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (in_take),
        .start_req  (start_req),
        .last       (last),
        .key_length (key_length),
        .data_word  (data_word),
        .byte_count (byte_count),
        .cmd        (cmd_in)
    );

    lk3_cmd_fifo u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (in_take),
        .din   (cmd_in),
        .rd_en (cmd_take),
        .dout  (cmd_out),
        .full  (full),
        .valid (cmd_valid)
    );

    lk3_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_out),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .adv       (adv),
        .wb        (wb),
        .hand      (hand),
        .kill      (kill)
    );

    lk3_final u_final (
        .clk        (clk),
        .rst_n      (rst_n),
        .hand       (hand),
        .kill       (kill),
        .adv        (adv),
        .wb         (wb),
        .pop        (pop),
        .empty      (empty),
        .hash_value (hash_value),
        .status     (status)
    );

endmodule
